@@ rtl/core/ofdmtx_pkg.sv @@
package ofdmtx_pkg;

    localparam int          TRAINING_INTERVAL_DEF = 4;
    localparam int          PREAMBLE_COUNT_DEF    = 4;
    localparam int          AMP_W                 = 15;
    localparam int          VAL_W                 = 16;
    localparam int          NUM_BINS              = 5;
    localparam int          NUM_VALS              = 2 * NUM_BINS;
    localparam int          CD_W                  = 3;
    localparam logic [14:0] AMP_RESET             = 15'd1024;
    localparam logic [7:0]  SCRAMBLER_SEED        = 8'hFF;

    typedef enum logic [1:0] {
        KIND_PREAMBLE = 2'd0,
        KIND_TRAINING = 2'd1,
        KIND_DATA     = 2'd2
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] bits;
        logic       pilot_neg;
        logic       last;
    } t_sym_req;

    typedef struct packed {
        t_kind                                 kind;
        logic [NUM_VALS-1:0][VAL_W-1:0]        vals;
        logic                                  last;
    } t_sym;

    function automatic logic [7:0] lfsr_step8(input logic [7:0] seed);
        logic [7:0] r;
        r = seed;
        for (int k = 0; k < 8; k++) begin
            r = {r[6:0], r[3] ^ r[6]};
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] carrier(input logic [AMP_W-1:0] amp,
                                                 input logic positive);
        logic [VAL_W-1:0] v;
        v = {1'b0, amp};
        return positive ? v : (~v + 16'd1);
    endfunction

endpackage

@@ rtl/core/ofdmtx_mapper.sv @@
module ofdmtx_mapper (
    input  ofdmtx_pkg::t_sym_req            i_req,
    input  logic [ofdmtx_pkg::AMP_W-1:0]    i_amp,
    output ofdmtx_pkg::t_sym                o_sym
);
    import ofdmtx_pkg::*;

    logic [VAL_W-1:0] pos_val;
    logic [VAL_W-1:0] neg_val;

    assign pos_val = carrier(i_amp, 1'b1);
    assign neg_val = carrier(i_amp, 1'b0);

    always_comb begin
        o_sym.kind = i_req.kind;
        o_sym.last = i_req.last;
        o_sym.vals = '0;
        unique case (i_req.kind)
            KIND_PREAMBLE: begin
                for (int b = 0; b < NUM_BINS; b++) begin
                    o_sym.vals[2*b] = neg_val;
                end
            end
            KIND_TRAINING: begin
                for (int b = 0; b < NUM_BINS; b++) begin
                    o_sym.vals[2*b] = pos_val;
                end
            end
            default: begin
                // msb first onto bins -2, -1, +1, +2, i then q
                o_sym.vals[0] = i_req.bits[7] ? pos_val : neg_val;
                o_sym.vals[1] = i_req.bits[6] ? pos_val : neg_val;
                o_sym.vals[2] = i_req.bits[5] ? pos_val : neg_val;
                o_sym.vals[3] = i_req.bits[4] ? pos_val : neg_val;
                o_sym.vals[4] = i_req.pilot_neg ? neg_val : pos_val;
                o_sym.vals[6] = i_req.bits[3] ? pos_val : neg_val;
                o_sym.vals[7] = i_req.bits[2] ? pos_val : neg_val;
                o_sym.vals[8] = i_req.bits[1] ? pos_val : neg_val;
                o_sym.vals[9] = i_req.bits[0] ? pos_val : neg_val;
            end
        endcase
    end

endmodule

@@ rtl/core/ofdmtx_seq.sv @@
module ofdmtx_seq #(
    parameter int TRAINING_INTERVAL = ofdmtx_pkg::TRAINING_INTERVAL_DEF,
    parameter int PREAMBLE_COUNT    = ofdmtx_pkg::PREAMBLE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_sop,
    input  logic                  i_advance,
    output ofdmtx_pkg::t_sym_req  o_req
);
    import ofdmtx_pkg::*;

    localparam int PRE_W = $clog2(PREAMBLE_COUNT + 1);

    logic             r_hold_valid;
    logic [7:0]       r_byte;
    logic [PRE_W-1:0] r_pre_left;
    logic [7:0]       r_scr;
    logic [CD_W-1:0]  r_cd;
    logic             r_pilot;

    logic [7:0]       n_scr;
    logic             emit;
    logic             is_pre;
    logic             is_train;
    logic             done;
    logic             accept;

    assign n_scr    = lfsr_step8(r_scr);
    assign emit     = r_hold_valid && i_advance;
    assign is_pre   = (r_pre_left != '0);
    assign is_train = !is_pre && (r_cd == '0);
    assign done     = emit && !is_pre && !is_train;
    assign o_ready  = !r_hold_valid || done;
    assign accept   = i_valid && o_ready;

    always_comb begin
        o_req.valid     = emit;
        o_req.bits      = r_byte ^ n_scr;
        o_req.pilot_neg = r_pilot;
        o_req.last      = 1'b0;
        if (is_pre) begin
            o_req.kind = KIND_PREAMBLE;
        end else if (is_train) begin
            o_req.kind = KIND_TRAINING;
        end else begin
            o_req.kind = KIND_DATA;
            o_req.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_pre_left   <= '0;
            r_scr        <= SCRAMBLER_SEED;
            r_cd         <= '0;
            r_pilot      <= 1'b0;
        end else begin
            if (accept) begin
                r_hold_valid <= 1'b1;
            end else if (done) begin
                r_hold_valid <= 1'b0;
            end
            if (accept) begin
                r_pre_left <= i_sop ? PRE_W'(PREAMBLE_COUNT) : '0;
            end else if (emit && is_pre) begin
                r_pre_left <= r_pre_left - 1'b1;
            end
            // a start request overrides the previous byte's update
            if (accept && i_sop) begin
                r_scr   <= SCRAMBLER_SEED;
                r_cd    <= '0;
                r_pilot <= 1'b0;
            end else if (emit && !is_pre) begin
                if (is_train) begin
                    r_cd <= CD_W'(TRAINING_INTERVAL);
                end else begin
                    r_scr   <= n_scr;
                    r_cd    <= r_cd - 1'b1;
                    r_pilot <= !r_pilot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end
    end

endmodule

@@ rtl/core/ofdm_tx_symbol_framer_top.sv @@
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: data_byte; tuser: start_of_packet
// m_axis    out  m_axis_tvalid/tready      tdata: ten carrier values; tuser: symbol_kind;
//                                          tlast: last_of_run
// cfg       in   i_cfg_wr_en               i_cfg_wr_data: amplitude
//
// one result leaves the output register per cycle unless tready is low; a byte yields its
// data symbol, after a training one at countdown 0, and PREAMBLE_COUNT for a start request.
// the sequencer holds one byte and takes the next in the cycle its data symbol issues.
// synchronous active-low reset: amplitude 1024, scrambler 0xff, countdown 0, pilot +.
// a stalled output holds its register and stops the sequencer; input waits on tready.
module ofdm_tx_symbol_framer_top #(
    parameter int TRAINING_INTERVAL = ofdmtx_pkg::TRAINING_INTERVAL_DEF,
    parameter int PREAMBLE_COUNT    = ofdmtx_pkg::PREAMBLE_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [14:0]   i_cfg_wr_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // data_byte
    input  logic          s_axis_tuser,   // start_of_packet
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // i_bin_m2, q_bin_m2, i_bin_m1, q_bin_m1, i_bin_dc, q_bin_dc,
    // i_bin_p1, q_bin_p1, i_bin_p2, q_bin_p2
    output logic [159:0]  m_axis_tdata,
    output logic [1:0]    m_axis_tuser,   // symbol_kind
    output logic          m_axis_tlast    // last_of_run
);
    import ofdmtx_pkg::*;

    logic [AMP_W-1:0] r_amp;
    logic             r_out_valid;
    t_sym             r_out;

    logic             advance;
    t_sym_req         req;
    t_sym             sym;

    assign advance = !r_out_valid || m_axis_tready;

    ofdmtx_seq #(
        .TRAINING_INTERVAL (TRAINING_INTERVAL),
        .PREAMBLE_COUNT    (PREAMBLE_COUNT)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_sop     (s_axis_tuser),
        .i_advance (advance),
        .o_req     (req)
    );

    ofdmtx_mapper u_mapper (
        .i_req (req),
        .i_amp (r_amp),
        .o_sym (sym)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp       <= AMP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_amp <= i_cfg_wr_data;
            end
            if (advance) begin
                r_out_valid <= req.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && req.valid) begin
            r_out <= sym;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.vals;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import ofdmtx_pkg::*;

    localparam int TRAIN_IVAL = TRAINING_INTERVAL_DEF;
    localparam int PRE_CNT    = PREAMBLE_COUNT_DEF;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_wr_en = 1'b0;
    logic [14:0]    i_cfg_wr_data = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata = '0;
    logic           s_axis_tuser = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [159:0]   m_axis_tdata;
    logic [1:0]     m_axis_tuser;
    logic           m_axis_tlast;

    ofdm_tx_symbol_framer_top #(
        .TRAINING_INTERVAL (TRAIN_IVAL),
        .PREAMBLE_COUNT    (PRE_CNT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // framer state mirrored by the testbench
    logic [14:0]    amp_cfg   = AMP_RESET;
    logic [7:0]     scr_state = SCRAMBLER_SEED;
    logic [2:0]     train_cd  = '0;
    logic           pilot_neg = 1'b0;

    t_sym           symbol_q[$];
    int             errors = 0;

    int             burst_left = 1;
    int             hold_req = 0;
    int             hold_left = 0;
    int             rx_mode = 0;
    int             rx_tick = 0;

    string          val_name[10] = '{"i_bin_m2", "q_bin_m2", "i_bin_m1", "q_bin_m1",
                                     "i_bin_dc", "q_bin_dc", "i_bin_p1", "q_bin_p1",
                                     "i_bin_p2", "q_bin_p2"};

    function automatic logic [15:0] carrier_val(input logic [14:0] amp, input logic positive);
        logic [15:0] mag;
        mag = {1'b0, amp};
        return positive ? mag : 16'(16'd0 - mag);
    endfunction

    function automatic t_sym flat_symbol(input t_kind kind, input logic positive);
        t_sym s;
        s.kind = kind;
        for (int b = 0; b < NUM_BINS; b++) begin
            s.vals[2 * b]     = carrier_val(amp_cfg, positive);
            s.vals[2 * b + 1] = '0;
        end
        s.last = 1'b0;
        return s;
    endfunction

    // symbols caused by one accepted byte request
    task automatic frame_byte(input logic [7:0] data, input logic sop);
        t_sym       s;
        logic [7:0] r;
        logic [7:0] bits;
        int         slot;
        if (sop) begin
            scr_state = SCRAMBLER_SEED;
            train_cd  = '0;
            pilot_neg = 1'b0;
            for (int p = 0; p < PRE_CNT; p++) begin
                symbol_q.push_back(flat_symbol(KIND_PREAMBLE, 1'b0));
            end
        end
        if (train_cd == 3'd0) begin
            symbol_q.push_back(flat_symbol(KIND_TRAINING, 1'b1));
            train_cd = 3'(TRAIN_IVAL);
        end
        train_cd = train_cd - 3'd1;
        r = scr_state;
        for (int k = 0; k < 8; k++) begin
            r = 8'((r << 1) | (((r >> 3) ^ (r >> 6)) & 8'h01));
        end
        scr_state = r;
        bits = data ^ r;
        s.kind = KIND_DATA;
        for (int b = 0; b < 4; b++) begin
            slot = (b < 2) ? 2 * b : 2 * b + 2;
            s.vals[slot]     = carrier_val(amp_cfg, bits[7 - 2 * b]);
            s.vals[slot + 1] = carrier_val(amp_cfg, bits[6 - 2 * b]);
        end
        s.vals[4] = carrier_val(amp_cfg, ~pilot_neg);
        s.vals[5] = '0;
        s.last    = 1'b1;
        symbol_q.push_back(s);
        pilot_neg = ~pilot_neg;
    endtask

    // called just after a falling edge with no write to tvalid yet in that step
    task automatic send_byte(input logic [7:0] data, input logic sop);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= sop;
        do @(posedge i_clk); while (!s_axis_tready);
        frame_byte(data, sop);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic end_stream();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (symbol_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_amplitude(input logic [14:0] value);
        drain();
        repeat (8) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        amp_cfg = value;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v),
                   $signed(act_v));
            errors++;
        end
    endtask

    // receiver stall pattern and long hold-off
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        rx_tick++;
        if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_tick % 4 == 0);
                default: m_axis_tready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_sym want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (symbol_q.size() == 0) begin
                $error("unexpected symbol: kind %0d", m_axis_tuser);
                errors++;
            end else begin
                want = symbol_q.pop_front();
                check_field("symbol_kind", 16'(want.kind), 16'(m_axis_tuser));
                for (int v = 0; v < NUM_VALS; v++) begin
                    check_field(val_name[v], want.vals[v], m_axis_tdata[16 * v +: 16]);
                end
                check_field("last_of_run", 16'(want.last), 16'(m_axis_tlast));
            end
        end
    end

    task automatic test_reset_state();
        logic [7:0] seq[8] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h3C, 8'hC3};
        @(negedge i_clk);
        // bytes without start right after reset, then a packet across a training period
        foreach (seq[i]) send_byte(seq[i], i == 2);
        end_stream();
    endtask

    task automatic test_amplitude_extremes();
        set_amplitude(15'h7FFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h96, 1'b0);
        end_stream();
        set_amplitude(15'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h69, 1'b0);
        end_stream();
        // zero amplitude gives all-zero carriers
        set_amplitude(15'd0);
        send_byte(8'h12, 1'b1);
        send_byte(8'hED, 1'b0);
        end_stream();
    endtask

    task automatic test_packet_restart();
        set_amplitude(AMP_RESET);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7E, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'hEE, 1'b1);
        end_stream();
    endtask

    task automatic test_random_packets();
        logic [14:0] amps[5];
        int          sent;
        int          len;
        amps[0] = 15'h7FFF;
        amps[1] = 15'd1;
        for (int i = 2; i < 5; i++) amps[i] = 15'($urandom_range(1, 32767));
        foreach (amps[ph]) begin
            set_amplitude(amps[ph]);
            sent = 0;
            while (sent < 40) begin
                // mostly packets with a start byte; sometimes bytes with no start
                if ($urandom_range(0, 9) != 0) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    sent++;
                end
                len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 14);
                repeat (len) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    sent++;
                end
            end
            end_stream();
        end
    endtask

    task automatic test_backpressure();
        set_amplitude(15'($urandom_range(1, 32767)));
        hold_req = 400;
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (29) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end_stream();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_amplitude_extremes();
        test_packet_restart();
        test_random_packets();
        test_backpressure();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ofdm_tx_symbol_framer_top verification clean");
        end else begin
            $display("ofdm_tx_symbol_framer_top verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("ofdm_tx_symbol_framer_top verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ofdmtx_pkg.sv
rtl/core/ofdmtx_mapper.sv
rtl/core/ofdmtx_seq.sv
rtl/core/ofdm_tx_symbol_framer_top.sv
tb/tb_top.sv
